@@ hw/rtl/rpv_pkg.sv @@
package rpv_pkg;

    localparam int FRACTION_BITS     = 16;
    localparam int CORDIC_ITERATIONS = 18;
    localparam int ANGLE_W           = FRACTION_BITS + 3;

    // datapath widths
    localparam int DW      = 64;
    localparam int ZW      = 35;
    localparam int SHIFT_W = 5;
    localparam int DEG_W   = (FRACTION_BITS + 11 > 27) ? FRACTION_BITS + 11 : 27;
    localparam int KDEG_W  = 26;
    localparam int PROD_W  = DEG_W + KDEG_W;
    localparam int CS_W    = 33;
    localparam int MUL_W   = 66;

    // q30 constants
    localparam longint PI_Q30_L       = 64'sd3373259426;
    localparam longint HALF_PI_Q30_L  = 64'sd1686629713;
    localparam longint INV_GAIN_Q30_L = 64'sd652032874;
    localparam longint DEG_RAD_Q30_L  = 64'sd18740330;
    localparam longint ANG_RND_L      = 64'sd1 <<< (29 - FRACTION_BITS);
    localparam longint ANG_CLAMP_L    = (PI_Q30_L + ANG_RND_L) >>> (30 - FRACTION_BITS);

    localparam logic signed [ZW-1:0]     PI_Q30       = ZW'(PI_Q30_L);
    localparam logic signed [ZW-1:0]     HALF_PI_Q30  = ZW'(HALF_PI_Q30_L);
    localparam logic signed [DW-1:0]     INV_GAIN_Q30 = DW'(INV_GAIN_Q30_L);
    localparam logic signed [KDEG_W-1:0] DEG_RAD_Q30  = KDEG_W'(DEG_RAD_Q30_L);
    localparam logic signed [ZW-1:0]     ANG_RND      = ZW'(ANG_RND_L);
    localparam logic signed [ZW-1:0]     ANG_CLAMP    = ZW'(ANG_CLAMP_L);

    // degree wrap constants
    localparam logic signed [DEG_W-1:0] DEG_FULL = DEG_W'(64'sd360 <<< FRACTION_BITS);
    localparam logic signed [DEG_W-1:0] DEG_HALF = DEG_W'(64'sd180 <<< FRACTION_BITS);

    typedef enum logic [1:0] {
        ACT_LOAD_RECT  = 2'd0,
        ACT_LOAD_POLAR = 2'd1,
        ACT_ADD_RECT   = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    // data handed from one cordic cell to the next
    typedef struct packed {
        logic                 vect;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } cell_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [SHIFT_W-1:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0:    v = ZW'(64'h3243F6A8);
                5'd1:    v = ZW'(64'h1DAC6705);
                5'd2:    v = ZW'(64'h0FADBAFC);
                5'd3:    v = ZW'(64'h07F56EA6);
                5'd4:    v = ZW'(64'h03FEAB76);
                5'd5:    v = ZW'(64'h01FFD55B);
                5'd6:    v = ZW'(64'h00FFFAAA);
                5'd7:    v = ZW'(64'h007FFF55);
                5'd8:    v = ZW'(64'h003FFFEA);
                5'd9:    v = ZW'(64'h001FFFFD);
                5'd10:   v = ZW'(64'h000FFFFF);
                5'd11:   v = ZW'(64'h0007FFFF);
                5'd12:   v = ZW'(64'h0003FFFF);
                5'd13:   v = ZW'(64'h0001FFFF);
                5'd14:   v = ZW'(64'h0000FFFF);
                5'd15:   v = ZW'(64'h00007FFF);
                5'd16:   v = ZW'(64'h00003FFF);
                5'd17:   v = ZW'(64'h00001FFF);
                5'd18:   v = ZW'(64'h00000FFF);
                5'd19:   v = ZW'(64'h000007FF);
                5'd20:   v = ZW'(64'h000003FF);
                5'd21:   v = ZW'(64'h000001FF);
                5'd22:   v = ZW'(64'h000000FF);
                5'd23:   v = ZW'(64'h0000007F);
                5'd24:   v = ZW'(64'h0000003F);
                5'd25:   v = ZW'(64'h0000001F);
                5'd26:   v = ZW'(64'h0000000F);
                5'd27:   v = ZW'(64'h00000008);
                5'd28:   v = ZW'(64'h00000004);
                5'd29:   v = ZW'(64'h00000002);
                5'd30:   v = ZW'(64'h00000001);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // q30 radians to output angle, rounded and clamped to +-pi
    function automatic logic signed [ANGLE_W-1:0] q30_to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        begin
            r = (z + ANG_RND) >>> (30 - FRACTION_BITS);
            if (r > ANG_CLAMP) begin
                r = ANG_CLAMP;
            end
            if (r < -ANG_CLAMP) begin
                r = -ANG_CLAMP;
            end
            return r[ANGLE_W-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/rpv_cordic_cell.sv @@
module rpv_cordic_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rpv_pkg::SHIFT_W-1:0]          shift,
    input  logic signed [rpv_pkg::ZW-1:0]        angle_step,
    input  logic                                 src_valid,
    input  rpv_pkg::cell_t                       src_data,
    output logic                                 dst_valid,
    output rpv_pkg::cell_t                       dst_data
);

    logic                          valid_reg;
    rpv_pkg::cell_t                data_reg;
    rpv_pkg::cell_t                data_next;
    logic signed [rpv_pkg::DW-1:0] xi;
    logic signed [rpv_pkg::DW-1:0] yi;
    logic signed [rpv_pkg::ZW-1:0] zi;
    logic signed [rpv_pkg::DW-1:0] xs;
    logic signed [rpv_pkg::DW-1:0] ys;
    logic                          plus;

    always_comb
    begin
        xi   = src_data.x;
        yi   = src_data.y;
        zi   = src_data.z;
        xs   = xi >>> shift;
        ys   = yi >>> shift;
        // vectoring drives y to zero, rotation drives z to zero
        plus = src_data.vect ? (yi > 0) : (zi < 0);
        data_next      = src_data;
        if (plus)
        begin
            data_next.x = xi + ys;
            data_next.y = yi - xs;
            data_next.z = zi + angle_step;
        end
        else
        begin
            data_next.x = xi - ys;
            data_next.y = yi + xs;
            data_next.z = zi - angle_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

endmodule

@@ hw/rtl/rpv_cordic_chain.sv @@
module rpv_cordic_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    input  rpv_pkg::cell_t src_data,
    output logic           dst_valid,
    output rpv_pkg::cell_t dst_data
);

    logic           valid_w [0:rpv_pkg::CORDIC_ITERATIONS];
    rpv_pkg::cell_t data_w  [0:rpv_pkg::CORDIC_ITERATIONS];

    assign valid_w[0] = src_valid;
    assign data_w[0]  = src_data;

    for (genvar k = 0; k < rpv_pkg::CORDIC_ITERATIONS; k++)
    begin : g_cell
        rpv_cordic_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (rpv_pkg::SHIFT_W'(k)),
            .angle_step (rpv_pkg::atan_q30(rpv_pkg::SHIFT_W'(k))),
            .src_valid  (valid_w[k]),
            .src_data   (data_w[k]),
            .dst_valid  (valid_w[k+1]),
            .dst_data   (data_w[k+1])
        );
    end

    assign dst_valid = valid_w[rpv_pkg::CORDIC_ITERATIONS];
    assign dst_data  = data_w[rpv_pkg::CORDIC_ITERATIONS];

endmodule

@@ hw/rtl/rpv_isqrt.sv @@
module rpv_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg,   n_next;
    logic [63:0] r_reg,   r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] trial;

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        root_next = root_reg;
        trial     = r_reg + bit_reg;
        if (start)
        begin
            n_next    = radicand;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (bit_reg != '0)
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                // round to nearest
                root_next = (n_reg > r_reg) ? 32'(r_reg + 64'd1) : r_reg[31:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hw/rtl/rect_polar_vector_converter_core.sv @@
// the result of load or add rectangular waits on the 32-step square root; load polar waits
//   on the 18-cell cordic chain; clear goes from accept straight to the output hand-over
// only one request in flight; the next request is taken once the result is in the output
//   register, even while that result still waits
// reset: asynchronous active low, clears the vector to zero and empties the output
module rect_polar_vector_converter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                request_valid,
    output logic                                request_stall,
    input  logic [1:0]                          action,
    input  logic signed [31:0]                  first_value,
    input  logic signed [25:0]                  second_value,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [31:0]                  x_out,
    output logic signed [31:0]                  y_out,
    output logic [31:0]                         magnitude_out,
    output logic signed [rpv_pkg::ANGLE_W-1:0]  angle_out,
    output logic                                mode_error,
    output logic                                saturated
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SQ   = 15'b000000000000010,   // abs values, squares, leading zeros
        S_NORM = 15'b000000000000100,   // normalize, start root and chain
        S_VEC  = 15'b000000000001000,   // wait for vectoring chain
        S_ROOT = 15'b000000000010000,   // wait for square root
        S_POL1 = 15'b000000000100000,   // remainder by a full turn
        S_POL2 = 15'b000000001000000,   // wrap into (-180, 180]
        S_POL3 = 15'b000000010000000,   // degrees to radians product
        S_POL4 = 15'b000000100000000,   // round to q30 radians
        S_POL5 = 15'b000001000000000,   // heading, quadrant fold, start chain
        S_ROT  = 15'b000010000000000,   // wait for rotation chain
        S_PMUL = 15'b000100000000000,   // magnitude times cos and sin
        S_PRND = 15'b001000000000000,   // round and clip to 32 bits
        S_DONE = 15'b010000000000000,   // hand over to the output register
        S_SPARE = 15'b100000000000000
    } state_t;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
    localparam int                 RAD_SH    = rpv_pkg::FRACTION_BITS;
    localparam logic signed [rpv_pkg::PROD_W-1:0] RAD_RND =
        rpv_pkg::PROD_W'(64'sd1 <<< (rpv_pkg::FRACTION_BITS - 1));
    localparam logic signed [rpv_pkg::MUL_W-1:0]  XY_RND  =
        rpv_pkg::MUL_W'(64'sd1 <<< 29);

    state_t state_reg, state_next;

    // stored vector
    logic signed [31:0]                 pos_x_reg, pos_x_next;
    logic signed [31:0]                 pos_y_reg, pos_y_next;
    logic [31:0]                        length_reg, length_next;
    logic signed [rpv_pkg::ANGLE_W-1:0] heading_reg, heading_next;
    logic                               err_reg, err_next;
    logic                               clip_reg, clip_next;

    // rectangular to polar working registers
    logic [31:0]  ux_reg, ux_next;
    logic [31:0]  uy_reg, uy_next;
    logic [63:0]  sqx_reg, sqx_next;
    logic [63:0]  sqy_reg, sqy_next;
    logic [4:0]   lz_reg, lz_next;
    logic         zero_reg, zero_next;
    logic         xneg_reg, xneg_next;
    logic         yneg_reg, yneg_next;

    // polar to rectangular working registers
    logic [31:0]                          mag_reg, mag_next;
    logic signed [rpv_pkg::DEG_W-1:0]     deg_reg, deg_next;
    logic signed [rpv_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [rpv_pkg::ZW-1:0]        rad_reg, rad_next;
    logic                                 flip_reg, flip_next;
    logic signed [rpv_pkg::CS_W-1:0]      cx_reg, cx_next;
    logic signed [rpv_pkg::CS_W-1:0]      cy_reg, cy_next;
    logic signed [rpv_pkg::MUL_W-1:0]     px_reg, px_next;
    logic signed [rpv_pkg::MUL_W-1:0]     py_reg, py_next;

    // output register
    logic                               rsp_valid_reg, rsp_valid_next;
    logic signed [31:0]                 x_out_reg, x_out_next;
    logic signed [31:0]                 y_out_reg, y_out_next;
    logic [31:0]                        mag_out_reg, mag_out_next;
    logic signed [rpv_pkg::ANGLE_W-1:0] ang_out_reg, ang_out_next;
    logic                               err_out_reg, err_out_next;
    logic                               sat_out_reg, sat_out_next;

    // combinational helpers
    logic                            accept;
    logic signed [32:0]              sum_x;
    logic signed [32:0]              sum_y;
    logic [31:0]                     ux_c;
    logic [31:0]                     uy_c;
    logic [31:0]                     m_c;
    logic [31:0]                     mm;
    logic [6:0]                      norm_sh;
    logic signed [rpv_pkg::DW-1:0]   xs_c;
    logic signed [rpv_pkg::DW-1:0]   ys_c;
    logic signed [rpv_pkg::ZW-1:0]   zr_c;
    logic signed [rpv_pkg::CS_W-1:0] c_c;
    logic signed [rpv_pkg::CS_W-1:0] s_c;
    logic signed [rpv_pkg::MUL_W-1:0] tx_c;
    logic signed [rpv_pkg::MUL_W-1:0] ty_c;

    // cordic chain and square root
    logic           chain_src_valid;
    rpv_pkg::cell_t chain_src;
    logic           chain_dst_valid;
    rpv_pkg::cell_t chain_dst;
    logic           root_start;
    logic [63:0]    root_radicand;
    logic           root_done;
    logic [31:0]    root_value;

    rpv_cordic_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (chain_src_valid),
        .src_data  (chain_src),
        .dst_valid (chain_dst_valid),
        .dst_data  (chain_dst)
    );

    rpv_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (root_radicand),
        .done     (root_done),
        .root     (root_value)
    );

    // only one request is worked on at a time
    assign request_stall = (state_reg != S_IDLE);
    assign accept        = request_valid && !request_stall;

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        length_next    = length_reg;
        heading_next   = heading_reg;
        err_next       = err_reg;
        clip_next      = clip_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        lz_next        = lz_reg;
        zero_next      = zero_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        mag_next       = mag_reg;
        deg_next       = deg_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        flip_next      = flip_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        rsp_valid_next = rsp_valid_reg;
        x_out_next     = x_out_reg;
        y_out_next     = y_out_reg;
        mag_out_next   = mag_out_reg;
        ang_out_next   = ang_out_reg;
        err_out_next   = err_out_reg;
        sat_out_next   = sat_out_reg;

        chain_src_valid = 1'b0;
        chain_src       = '0;
        root_start      = 1'b0;
        root_radicand   = sqx_reg + sqy_reg;

        // saturating add of the request to the stored vector
        sum_x = 33'(pos_x_reg) + 33'(first_value);
        sum_y = 33'(pos_y_reg) + 33'(second_value);

        // magnitudes and leading zeros of the larger one
        ux_c = pos_x_reg[31] ? 32'(-pos_x_reg) : pos_x_reg;
        uy_c = pos_y_reg[31] ? 32'(-pos_y_reg) : pos_y_reg;
        m_c  = (ux_c > uy_c) ? ux_c : uy_c;
        mm   = m_c;

        // normalize so the larger component has bit 59 set
        norm_sh = 7'd28 + 7'(lz_reg);
        xs_c    = rpv_pkg::DW'({32'b0, ux_reg}) <<< norm_sh;
        ys_c    = rpv_pkg::DW'({32'b0, uy_reg}) <<< norm_sh;

        zr_c = rpv_pkg::ZW'((prod_reg + RAD_RND) >>> RAD_SH);
        c_c  = chain_dst.x[rpv_pkg::CS_W-1:0];
        s_c  = chain_dst.y[rpv_pkg::CS_W-1:0];
        tx_c = (px_reg + XY_RND) >>> 30;
        ty_c = (py_reg + XY_RND) >>> 30;

        // output register drains independently of the work in progress
        if (rsp_valid_reg && !result_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_next  = 1'b0;
                    clip_next = 1'b0;
                    case (action)
                        rpv_pkg::ACT_LOAD_RECT:
                        begin
                            pos_x_next = first_value;
                            pos_y_next = 32'(second_value);
                            state_next = S_SQ;
                        end
                        rpv_pkg::ACT_LOAD_POLAR:
                        begin
                            // negative magnitude turns the vector by half a turn
                            if (first_value[31])
                            begin
                                mag_next = 32'(-first_value);
                                deg_next = rpv_pkg::DEG_W'(second_value) + rpv_pkg::DEG_HALF;
                            end
                            else
                            begin
                                mag_next = first_value;
                                deg_next = rpv_pkg::DEG_W'(second_value);
                            end
                            length_next = mag_next;
                            state_next  = S_POL1;
                        end
                        rpv_pkg::ACT_ADD_RECT:
                        begin
                            if (sum_x[32:31] == 2'b01)
                            begin
                                pos_x_next = INT32_MAX;
                                clip_next  = 1'b1;
                            end
                            else if (sum_x[32:31] == 2'b10)
                            begin
                                pos_x_next = INT32_MIN;
                                clip_next  = 1'b1;
                            end
                            else
                            begin
                                pos_x_next = sum_x[31:0];
                            end
                            if (sum_y[32:31] == 2'b01)
                            begin
                                pos_y_next = INT32_MAX;
                                clip_next  = 1'b1;
                            end
                            else if (sum_y[32:31] == 2'b10)
                            begin
                                pos_y_next = INT32_MIN;
                                clip_next  = 1'b1;
                            end
                            else
                            begin
                                pos_y_next = sum_y[31:0];
                            end
                            state_next = S_SQ;
                        end
                        default:
                        begin
                            // the clear action lands here: it clears the vector and flags a mode error
                            pos_x_next   = '0;
                            pos_y_next   = '0;
                            length_next  = '0;
                            heading_next = '0;
                            err_next     = 1'b1;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end

            S_SQ:
            begin
                ux_next   = ux_c;
                uy_next   = uy_c;
                sqx_next  = 64'(ux_c) * 64'(ux_c);
                sqy_next  = 64'(uy_c) * 64'(uy_c);
                xneg_next = pos_x_reg[31];
                yneg_next = pos_y_reg[31];
                zero_next = (m_c == '0);
                // leading zero count by halving steps
                lz_next   = '0;
                if (mm[31:16] == '0)
                begin
                    lz_next[4] = 1'b1;
                    mm = mm << 16;
                end
                if (mm[31:24] == '0)
                begin
                    lz_next[3] = 1'b1;
                    mm = mm << 8;
                end
                if (mm[31:28] == '0)
                begin
                    lz_next[2] = 1'b1;
                    mm = mm << 4;
                end
                if (mm[31:30] == '0)
                begin
                    lz_next[1] = 1'b1;
                    mm = mm << 2;
                end
                if (mm[31] == 1'b0)
                begin
                    lz_next[0] = 1'b1;
                end
                state_next = S_NORM;
            end

            S_NORM:
            begin
                root_start      = 1'b1;
                chain_src_valid = 1'b1;
                chain_src.vect  = 1'b1;
                chain_src.x     = xs_c;
                chain_src.y     = (yneg_reg != xneg_reg) ? -ys_c : ys_c;
                // left half plane starts from +-pi
                if (xneg_reg)
                begin
                    chain_src.z = yneg_reg ? -rpv_pkg::PI_Q30 : rpv_pkg::PI_Q30;
                end
                else
                begin
                    chain_src.z = '0;
                end
                state_next = S_VEC;
            end

            S_VEC:
            begin
                if (chain_dst_valid)
                begin
                    heading_next = zero_reg ? '0 : rpv_pkg::q30_to_angle(chain_dst.z);
                    state_next   = S_ROOT;
                end
            end

            S_ROOT:
            begin
                if (root_done)
                begin
                    length_next = root_value;
                    state_next  = S_DONE;
                end
            end

            S_POL1:
            begin
                if (deg_reg >= rpv_pkg::DEG_FULL)
                begin
                    deg_next = deg_reg - rpv_pkg::DEG_FULL;
                end
                else if (deg_reg <= -rpv_pkg::DEG_FULL)
                begin
                    deg_next = deg_reg + rpv_pkg::DEG_FULL;
                end
                state_next = S_POL2;
            end

            S_POL2:
            begin
                if (deg_reg > rpv_pkg::DEG_HALF)
                begin
                    deg_next = deg_reg - rpv_pkg::DEG_FULL;
                end
                else if (deg_reg <= -rpv_pkg::DEG_HALF)
                begin
                    deg_next = deg_reg + rpv_pkg::DEG_FULL;
                end
                state_next = S_POL3;
            end

            S_POL3:
            begin
                prod_next  = rpv_pkg::PROD_W'(deg_reg) * rpv_pkg::PROD_W'(rpv_pkg::DEG_RAD_Q30);
                state_next = S_POL4;
            end

            S_POL4:
            begin
                rad_next   = zr_c;
                state_next = S_POL5;
            end

            S_POL5:
            begin
                heading_next    = rpv_pkg::q30_to_angle(rad_reg);
                chain_src_valid = 1'b1;
                chain_src.vect  = 1'b0;
                chain_src.x     = rpv_pkg::INV_GAIN_Q30;
                chain_src.y     = '0;
                // fold into +-pi/2 and negate the result afterwards
                if (rad_reg > rpv_pkg::HALF_PI_Q30)
                begin
                    chain_src.z = rad_reg - rpv_pkg::PI_Q30;
                    flip_next   = 1'b1;
                end
                else if (rad_reg < -rpv_pkg::HALF_PI_Q30)
                begin
                    chain_src.z = rad_reg + rpv_pkg::PI_Q30;
                    flip_next   = 1'b1;
                end
                else
                begin
                    chain_src.z = rad_reg;
                    flip_next   = 1'b0;
                end
                state_next = S_ROT;
            end

            S_ROT:
            begin
                if (chain_dst_valid)
                begin
                    cx_next    = flip_reg ? -c_c : c_c;
                    cy_next    = flip_reg ? -s_c : s_c;
                    state_next = S_PMUL;
                end
            end

            S_PMUL:
            begin
                px_next    = rpv_pkg::MUL_W'($signed({1'b0, mag_reg})) * rpv_pkg::MUL_W'(cx_reg);
                py_next    = rpv_pkg::MUL_W'($signed({1'b0, mag_reg})) * rpv_pkg::MUL_W'(cy_reg);
                state_next = S_PRND;
            end

            S_PRND:
            begin
                // clip without flagging
                if (tx_c > rpv_pkg::MUL_W'(INT32_MAX))
                begin
                    pos_x_next = INT32_MAX;
                end
                else if (tx_c < rpv_pkg::MUL_W'(INT32_MIN))
                begin
                    pos_x_next = INT32_MIN;
                end
                else
                begin
                    pos_x_next = tx_c[31:0];
                end
                if (ty_c > rpv_pkg::MUL_W'(INT32_MAX))
                begin
                    pos_y_next = INT32_MAX;
                end
                else if (ty_c < rpv_pkg::MUL_W'(INT32_MIN))
                begin
                    pos_y_next = INT32_MIN;
                end
                else
                begin
                    pos_y_next = ty_c[31:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // load the output register once it is free or being taken
                if (!rsp_valid_reg || !result_stall)
                begin
                    rsp_valid_next = 1'b1;
                    x_out_next     = pos_x_reg;
                    y_out_next     = pos_y_reg;
                    mag_out_next   = length_reg;
                    ang_out_next   = heading_reg;
                    err_out_next   = err_reg;
                    sat_out_next   = clip_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            length_reg    <= '0;
            heading_reg   <= '0;
            err_reg       <= 1'b0;
            clip_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            length_reg    <= length_next;
            heading_reg   <= heading_next;
            err_reg       <= err_next;
            clip_reg      <= clip_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        lz_reg      <= lz_next;
        zero_reg    <= zero_next;
        xneg_reg    <= xneg_next;
        yneg_reg    <= yneg_next;
        mag_reg     <= mag_next;
        deg_reg     <= deg_next;
        prod_reg    <= prod_next;
        rad_reg     <= rad_next;
        flip_reg    <= flip_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        x_out_reg   <= x_out_next;
        y_out_reg   <= y_out_next;
        mag_out_reg <= mag_out_next;
        ang_out_reg <= ang_out_next;
        err_out_reg <= err_out_next;
        sat_out_reg <= sat_out_next;
    end

    assign result_valid  = rsp_valid_reg;
    assign x_out         = x_out_reg;
    assign y_out         = y_out_reg;
    assign magnitude_out = mag_out_reg;
    assign angle_out     = ang_out_reg;
    assign mode_error    = err_out_reg;
    assign saturated     = sat_out_reg;

endmodule
